// File: design/bfas_pkg.sv
// bfas_pkg: shared types, codes and helper functions of the bit field access splitter
// no dependencies; used by the channel interfaces and the top level

package bfas_pkg;

    localparam int MAX_FIELD_BITS_DEF = 64;
    localparam int ADDRESS_BITS_DEF   = 32;

    // request function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RESP  = 2'd2;

    // update rules
    localparam logic [1:0] UPD_PRESERVE = 2'd0;
    localparam logic [1:0] UPD_ONES     = 2'd1;
    localparam logic [1:0] UPD_ZEROS    = 2'd2;

    // access size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] bit_offset;
        logic [6:0]  bit_size;
        logic [1:0]  access_size_code;
        logic [1:0]  update_rule;
        logic [31:0] region_base;
        logic [63:0] write_data;
        logic [63:0] read_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [1:0]  size_code;
        logic [63:0] write_value;
        logic [63:0] field_value;
        logic        last;
    } t_rsp;

    // access width in bits: 8, 16, 32 or 64
    function automatic logic [6:0] access_bits(input logic [1:0] code);
        access_bits = 7'd8 << code;
    endfunction

    function automatic logic [63:0] width_mask(input logic [1:0] code);
        logic [63:0] m;
        case (code)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        width_mask = m;
    endfunction

endpackage

// File: design/bfas_if.sv
// bfas_if: valid/ready channel interfaces for requests and results
// depends on bfas_pkg for the payload structs

interface bfas_req_if;
    logic             valid;
    logic             ready;
    bfas_pkg::t_req   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface bfas_rsp_if;
    logic             valid;
    logic             ready;
    bfas_pkg::t_rsp   item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: design/bit_field_access_splitter.sv
// bit_field_access_splitter: cuts a field request into aligned bus accesses
// depends on bfas_pkg and the channels in bfas_if.sv
//
// Usage: requests arrive on i_req (valid/ready); every result leaves on o_rsp
// through one output register. A start request (field read or write) is turned
// into bus read and write commands, one access-width word each, and ends with a
// done result carrying a read's gathered field value. For every read command the
// sender must answer with a response request (func 2) carrying the bus word.
// i_req.ready is high only while the sequencer is idle or awaiting a response;
// the last result of a request may still sit in the output register then.
// Steps, from the accepting edge to the result: a start goes to the decision
// step, which loads its read command or its done; a write under the ones or
// zeros rule then alternates piece calculation and merge through the shared
// shift/mask unit, loading one write command per piece, and ends with a done.
// A response goes through piece calculation to its write command (writes only)
// and then to the next read command or done.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register; a pending request is forgotten.

module bit_field_access_splitter #(
    parameter int MAX_FIELD_BITS = bfas_pkg::MAX_FIELD_BITS_DEF,
    parameter int ADDRESS_BITS   = bfas_pkg::ADDRESS_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bfas_req_if.sink     i_req,
    bfas_rsp_if.source   o_rsp
);

    localparam int PW = $clog2(MAX_FIELD_BITS + 1);
    localparam int AW = ADDRESS_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_PIECE  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;
    localparam logic [2:0] ST_NEXT   = 3'd6;

    logic [2:0]                r_state, n_state;
    logic                      r_wr, n_wr;
    logic                      r_fill, n_fill;
    logic [PW-1:0]             r_pos, n_pos;
    logic [PW-1:0]             r_len, n_len;
    logic [AW-1:0]             r_addr, n_addr;
    logic [15:0]               r_start, n_start;
    logic [1:0]                r_code, n_code;
    logic [1:0]                r_rule, n_rule;
    logic [MAX_FIELD_BITS-1:0] r_new, n_new;
    logic [MAX_FIELD_BITS-1:0] r_gath, n_gath;
    logic [63:0]               r_base, n_base;
    logic [5:0]                r_off, n_off;
    logic [6:0]                r_bits, n_bits;
    logic [63:0]               r_mask, n_mask;

    logic                      r_ov;
    bfas_pkg::t_rsp            r_out;

    logic                      w_in_acc;
    logic                      w_free;
    logic                      w_load;
    bfas_pkg::t_rsp            w_res;
    logic [6:0]                w_acc;
    logic [6:0]                w_in_acc_bits;
    logic [15:0]               w_sum;
    logic [6:0]                w_off7;
    logic [6:0]                w_room;
    logic [6:0]                w_rem;
    logic [6:0]                w_pbits;
    logic [63:0]               w_wv;
    logic [63:0]               w_piece;
    logic                      w_bad_rule;
    logic [PW-1:0]             w_pos_adv;
    logic [AW-1:0]             w_addr_adv;

    assign i_req.ready = (r_state == ST_IDLE) || (r_state == ST_WAIT);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_free      = !r_ov || o_rsp.ready;
    assign o_rsp.valid = r_ov;
    assign o_rsp.item  = r_out;

    assign w_acc         = bfas_pkg::access_bits(r_code);
    assign w_in_acc_bits = bfas_pkg::access_bits(i_req.item.access_size_code);

    // piece of the field that starts at the current position
    assign w_sum   = r_start + 16'(r_pos);
    assign w_off7  = 7'(w_sum[5:0]) & (w_acc - 7'd1);
    assign w_room  = w_acc - w_off7;
    assign w_rem   = 7'(r_len - r_pos);
    assign w_pbits = (w_rem < w_room) ? w_rem : w_room;

    // shared shift and mask unit: merge for writes, extract for reads
    assign w_wv = ((r_base & ~(r_mask << r_off))
                  | (((64'(r_new) >> r_pos) & r_mask) << r_off))
                  & bfas_pkg::width_mask(r_code);
    assign w_piece = (r_base >> r_off) & r_mask;

    assign w_pos_adv  = r_pos + PW'(r_bits);
    assign w_addr_adv = r_addr + AW'(w_acc >> 3);

    assign w_bad_rule = r_wr && !(r_rule == bfas_pkg::UPD_PRESERVE
                                  || r_rule == bfas_pkg::UPD_ONES
                                  || r_rule == bfas_pkg::UPD_ZEROS);

    always_comb begin
        n_state = r_state;
        n_wr    = r_wr;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_len   = r_len;
        n_addr  = r_addr;
        n_start = r_start;
        n_code  = r_code;
        n_rule  = r_rule;
        n_new   = r_new;
        n_gath  = r_gath;
        n_base  = r_base;
        n_off   = r_off;
        n_bits  = r_bits;
        n_mask  = r_mask;
        w_load  = 1'b0;
        w_res   = '0;

        case (r_state)
            ST_IDLE, ST_WAIT: begin
                if (w_in_acc) begin
                    if (i_req.item.func == bfas_pkg::FUNC_READ
                        || i_req.item.func == bfas_pkg::FUNC_WRITE) begin
                        n_wr    = (i_req.item.func == bfas_pkg::FUNC_WRITE);
                        n_start = i_req.item.bit_offset;
                        n_len   = (i_req.item.bit_size > 7'(MAX_FIELD_BITS))
                                  ? PW'(MAX_FIELD_BITS) : PW'(i_req.item.bit_size);
                        n_code  = i_req.item.access_size_code;
                        n_rule  = i_req.item.update_rule;
                        n_new   = MAX_FIELD_BITS'(i_req.item.write_data);
                        n_gath  = '0;
                        n_pos   = '0;
                        n_addr  = AW'(i_req.item.region_base)
                                  + AW'((i_req.item.bit_offset
                                         & ~(16'(w_in_acc_bits) - 16'd1)) >> 3);
                        n_state = ST_DECIDE;
                    end else if (i_req.item.func == bfas_pkg::FUNC_RESP
                                 && r_state == ST_WAIT) begin
                        n_base  = i_req.item.read_data & bfas_pkg::width_mask(r_code);
                        n_fill  = 1'b0;
                        n_state = ST_PIECE;
                    end
                end
            end
            ST_DECIDE: begin
                if (r_len == '0 || w_bad_rule) begin
                    if (w_free) begin
                        w_load        = 1'b1;
                        w_res.kind    = bfas_pkg::KIND_DONE;
                        w_res.last    = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (!r_wr || r_rule == bfas_pkg::UPD_PRESERVE) begin
                    if (w_free) begin
                        w_load          = 1'b1;
                        w_res.kind      = bfas_pkg::KIND_READ;
                        w_res.address   = 32'(r_addr);
                        w_res.size_code = r_code;
                        w_res.last      = 1'b1;
                        n_state         = ST_WAIT;
                    end
                end else begin
                    n_base  = (r_rule == bfas_pkg::UPD_ONES) ? '1 : '0;
                    n_fill  = 1'b1;
                    n_state = ST_PIECE;
                end
            end
            ST_PIECE: begin
                n_off   = w_off7[5:0];
                n_bits  = w_pbits;
                n_mask  = (w_pbits >= 7'd64) ? '1 : ((64'd1 << w_pbits) - 64'd1);
                n_state = r_fill ? ST_FILL : ST_RESP;
            end
            ST_FILL: begin
                if (w_free) begin
                    w_load = 1'b1;
                    if (r_pos >= r_len) begin
                        w_res.kind = bfas_pkg::KIND_DONE;
                        w_res.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        w_res.kind        = bfas_pkg::KIND_WRITE;
                        w_res.address     = 32'(r_addr);
                        w_res.size_code   = r_code;
                        w_res.write_value = w_wv;
                        n_pos             = w_pos_adv;
                        n_addr            = w_addr_adv;
                        n_state           = ST_PIECE;
                    end
                end
            end
            ST_RESP: begin
                if (!r_wr) begin
                    n_gath  = r_gath | MAX_FIELD_BITS'(w_piece << r_pos);
                    n_pos   = w_pos_adv;
                    n_addr  = w_addr_adv;
                    n_state = ST_NEXT;
                end else if (w_free) begin
                    w_load            = 1'b1;
                    w_res.kind        = bfas_pkg::KIND_WRITE;
                    w_res.address     = 32'(r_addr);
                    w_res.size_code   = r_code;
                    w_res.write_value = w_wv;
                    n_pos             = w_pos_adv;
                    n_addr            = w_addr_adv;
                    n_state           = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (w_free) begin
                    w_load     = 1'b1;
                    w_res.last = 1'b1;
                    if (r_pos >= r_len) begin
                        w_res.kind        = bfas_pkg::KIND_DONE;
                        w_res.field_value = r_wr ? 64'd0 : 64'(r_gath);
                        n_state           = ST_IDLE;
                    end else begin
                        w_res.kind      = bfas_pkg::KIND_READ;
                        w_res.address   = 32'(r_addr);
                        w_res.size_code = r_code;
                        n_state         = ST_WAIT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wr    <= 1'b0;
            r_fill  <= 1'b0;
            r_pos   <= '0;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr    <= n_wr;
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_len   <= n_len;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_start <= n_start;
        r_code  <= n_code;
        r_rule  <= n_rule;
        r_new   <= n_new;
        r_gath  <= n_gath;
        r_base  <= n_base;
        r_off   <= n_off;
        r_bits  <= n_bits;
        r_mask  <= n_mask;
        if (w_load) begin
            r_out <= w_res;
        end
    end

    // a start transfer always goes to the decision step
    a_start_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_req.item.func == bfas_pkg::FUNC_READ
                      || i_req.item.func == bfas_pkg::FUNC_WRITE))
        |=> (r_state == ST_DECIDE))
        else $error("start transfer did not reach decision step");

    // the position never runs past the field length
    a_pos_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("position beyond field length");

    // every read command leaves the sequencer awaiting its response
    a_read_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.kind == bfas_pkg::KIND_READ) |=> (r_state == ST_WAIT))
        else $error("read command issued without awaiting response");

    // a done result closes its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.kind == bfas_pkg::KIND_DONE) |-> r_out.last)
        else $error("done result without last");

    // a stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |-> !w_load)
        else $error("output register overwritten while stalled");

endmodule
